[sv/eat_pkg.sv]
// eat_pkg: shared constants, types and helper functions for the elevation attribute tagger
// no dependencies; imported by eat_colour and elevation_attribute_tagger
`timescale 1ns / 1ps

package eat_pkg;

	localparam int TAG_STEP       = 10000;
	localparam int TAG_NEG        = 1000;
	localparam int SWAP_BIAS      = 41000 - 32768;
	localparam int BLACK_MAX_MEAN = 70;
	localparam int BLACK_SPREAD   = 10;
	localparam int RECIP3         = 683;
	localparam int RECIP3_SHIFT   = 11;
	localparam int NUM_CLASSES    = 8;

	localparam logic [7:0] USABLE_TAGS = 8'h7E;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAG_MASK = 1'b0,
		CFG_EXTENT   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		COL_NONE  = 2'd0,
		COL_BLACK = 2'd1,
		COL_GREEN = 2'd2,
		COL_BLUE  = 2'd3
	} colour_t;

	// base value of a tag class on the shifted scale
	function automatic logic [16:0] class_base(input logic [2:0] cls);
		return 17'(int'(cls) * TAG_STEP);
	endfunction

	// amount subtracted when tagging with a colour layer, (4 - colour) * step
	function automatic logic [15:0] colour_offset(input colour_t col);
		return 16'((4 - int'(col)) * TAG_STEP);
	endfunction

endpackage

[sv/eat_colour.sv]
// eat_colour: classifies one rgb pixel as blue, green, black or none from its mean
// depends on eat_pkg
`timescale 1ns / 1ps

module eat_colour (
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	output eat_pkg::colour_t colour
);
	import eat_pkg::*;

	logic [9:0]  sum;
	logic [19:0] prod;
	logic [7:0]  mean;
	logic [8:0]  mean2;
	logic [7:0]  diff_b;
	logic [7:0]  diff_g;
	logic        is_black;

	assign sum   = 10'(red) + 10'(green) + 10'(blue);
	// divide by three through a reciprocal, exact for sums up to 765
	assign prod  = 20'(sum) * 20'(RECIP3);
	assign mean  = prod[RECIP3_SHIFT +: 8];
	assign mean2 = {mean, 1'b0};

	assign diff_b = (mean >= blue)  ? (mean - blue)  : (blue - mean);
	assign diff_g = (mean >= green) ? (mean - green) : (green - mean);

	assign is_black = (mean < 8'(BLACK_MAX_MEAN)) && (diff_b < 8'(BLACK_SPREAD))
		&& (diff_g < 8'(BLACK_SPREAD));

	always_comb begin
		if ({1'b0, blue} >= mean2) begin
			colour = COL_BLUE;
		end else if ({1'b0, green} >= mean2) begin
			colour = COL_GREEN;
		end else if (is_black) begin
			colour = COL_BLACK;
		end else begin
			colour = COL_NONE;
		end
	end

endmodule

[sv/elevation_attribute_tagger.sv]
// elevation_attribute_tagger: top level, tag class clearing and colour tagging of samples
// depends on eat_pkg and eat_colour
`timescale 1ns / 1ps

// Takes one big-endian elevation sample with its rgb pixel per request and returns one
// result: the request is registered, the whole tag computation runs in one
// combinational pass, and the result register drives the outputs. busy is
// always low, so a request can be given in every cycle and results leave at one per
// clock. Each result is shown for exactly one cycle with result_valid high; the receiver
// cannot stall. Configuration writes are taken in any cycle (cfg_ready is always high)
// and must only be made while no request is in flight.
module elevation_attribute_tagger (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [15:0]                   raw_sample,
	input  logic [7:0]                    pixel_red,
	input  logic [7:0]                    pixel_green,
	input  logic [7:0]                    pixel_blue,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [eat_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]                    cfg_data,
	output logic                          result_valid,
	output logic [15:0]                   out_sample,
	output logic [2:0]                    class_before,
	output logic [1:0]                    colour_class,
	output logic                          changed
);
	import eat_pkg::*;

	logic [6:0]  tag_mask_q;
	logic        extent_q;

	logic        valid_s1;
	logic [15:0] raw_s1;
	logic [7:0]  red_s1;
	logic [7:0]  green_s1;
	logic [7:0]  blue_s1;

	logic        valid_s2;
	logic [15:0] sample_s2;
	logic [2:0]  class_s2;
	colour_t     colour_s2;
	logic        changed_s2;

	logic [15:0] swapped;
	logic [16:0] shifted;
	logic [2:0]  cls;
	logic [13:0] rem;
	logic [7:0]  mask;
	logic        cleared;
	logic [2:0]  cls_now;
	logic        evaluate;
	colour_t     pix_colour;
	colour_t     colour;
	logic        tag_hit;
	logic [15:0] value;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_mask_q <= '0;
			extent_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TAG_MASK: tag_mask_q <= cfg_data;
				CFG_EXTENT:   extent_q   <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			raw_s1   <= raw_sample;
			red_s1   <= pixel_red;
			green_s1 <= pixel_green;
			blue_s1  <= pixel_blue;
		end
	end

	eat_colour u_colour (
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.colour (pix_colour)
	);

	// signed height plus offset, always positive
	assign swapped = {raw_s1[7:0], raw_s1[15:8]};
	assign shifted = {1'b0, swapped ^ 16'h8000} + 17'(SWAP_BIAS);

	always_comb begin
		cls = '0;
		for (int k = 1; k < NUM_CLASSES; k++) begin
			if (shifted >= 17'(k * TAG_STEP)) begin
				cls = 3'(k);
			end
		end
	end

	assign rem     = 14'(shifted - class_base(cls));
	assign mask    = {1'b0, tag_mask_q} & USABLE_TAGS;
	assign cleared = mask[cls];
	// a cleared value always lands in the untagged class
	assign cls_now  = cleared ? 3'd4 : cls;
	assign evaluate = extent_q && USABLE_TAGS[cls_now];
	assign colour   = evaluate ? pix_colour : COL_NONE;
	assign tag_hit  = evaluate && mask[colour];

	always_comb begin
		if (tag_hit) begin
			value = 16'(rem) - 16'(TAG_NEG) - colour_offset(colour);
		end else if (cleared) begin
			value = 16'(rem) - 16'(TAG_NEG);
		end else begin
			value = swapped;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sample_s2  <= {value[7:0], value[15:8]};
			class_s2   <= cls;
			colour_s2  <= colour;
			changed_s2 <= cleared || tag_hit;
		end
	end

	assign result_valid = valid_s2;
	assign out_sample   = sample_s2;
	assign class_before = class_s2;
	assign colour_class = colour_s2;
	assign changed      = changed_s2;

	a_result_follows_request : assert property (
		@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, 2)
	) else $error("result without a request two cycles earlier");

	a_unchanged_passes_through : assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && !changed) |-> (out_sample == $past(raw_sample, 2))
	) else $error("unchanged sample differs from its request");

	a_error_class_no_colour : assert property (
		@(posedge clk) disable iff (!arst_n)
		(result_valid && (class_before == 3'd0 || class_before == 3'd7))
			|-> (colour_class == COL_NONE)
	) else $error("error pixel got a colour class");

endmodule
